// ===== hdl/bdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants and operation codes for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int WORD_BITS   = 32;

    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int CAP_W = 11;
    localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

    localparam int MODE_W      = 3;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_FIELD_W = 1 + 32 + 32 + 1 + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef logic [MODE_W-1:0] t_mode;

    localparam t_mode MODE_PUSH_FRONT = 3'd0;
    localparam t_mode MODE_PUSH_REAR  = 3'd1;
    localparam t_mode MODE_POP_FRONT  = 3'd2;
    localparam t_mode MODE_POP_REAR   = 3'd3;
    localparam t_mode MODE_STATUS     = 3'd4;

endpackage

// ===== hdl/bdq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/bounded_double_ended_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_top
// Deque of signed words in a ring buffer with a head pointer and a count.
//
// channel   direction  word
// s_axis    in         tuser: mode [2:0]; tdata: data_value [31:0]
// m_axis    out        tdata: accepted, front_value, rear_value, is_empty,
//                      is_full, zero pad
// cfg       in         i_cfg_wr_data: capacity, written when i_cfg_wr_en
//
// Each word passes through accept and update, read front, read rear and
// load the output register, in that order; the single read port of the RAM sets this.
// A word is taken while the previous result still waits in the output
// register; the last step holds while that register is full and m_axis_tready is low.
// Synchronous active-low reset clears pointer, count, state and output valid,
// and sets the capacity to 1024; RAM contents are undefined until written.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_top
    import bdq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // data_value
    input  logic [MODE_W-1:0]      s_axis_tuser,   // mode
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // accepted, front, rear, empty, full
    input  logic                   i_cfg_wr_en,
    input  logic [CAP_W-1:0]       i_cfg_wr_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FRONT = 4'b0010,
        S_REAR  = 4'b0100,
        S_LAST  = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_head, n_head;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_ok, n_ok;
    logic [CAP_W-1:0]       r_cap;
    logic [WORD_BITS-1:0]   r_front;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                   w_accept;
    logic                   w_full;
    logic                   w_empty;
    logic [CMP_W-1:0]       w_eff_cap;
    logic                   w_out_free;
    logic                   w_wr_en;
    logic [IDX_W-1:0]       w_wr_addr;
    logic                   w_rd_en;
    logic [IDX_W-1:0]       w_rd_addr;
    logic [IDX_W-1:0]       w_rear_addr;
    logic [WORD_BITS-1:0]   w_rd_data;
    t_mode                  w_mode;

    function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] a, logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
        if (s >= (CNT_W+1)'(STORE_DEPTH)) begin
            s = s - (CNT_W+1)'(STORE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    assign w_mode     = s_axis_tuser;
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_eff_cap  = (CMP_W'(r_cap) > CMP_W'(STORE_DEPTH)) ? CMP_W'(STORE_DEPTH)
                                                              : CMP_W'(r_cap);
    assign w_full     = CMP_W'(r_count) >= w_eff_cap;
    assign w_empty    = (r_count == '0);
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_rear_addr = wrap_add(r_head, r_count - CNT_W'(1));

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // operation decode and ring update
    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_ok      = 1'b0;
        w_wr_en   = 1'b0;
        w_wr_addr = wrap_add(r_head, r_count);
        case (w_mode)
            MODE_PUSH_FRONT: begin
                if (!w_full) begin
                    n_head    = (r_head == '0) ? IDX_W'(STORE_DEPTH - 1) : r_head - IDX_W'(1);
                    w_wr_addr = n_head;
                    w_wr_en   = w_accept;
                    n_count   = r_count + CNT_W'(1);
                    n_ok      = 1'b1;
                end
            end
            MODE_PUSH_REAR: begin
                if (!w_full) begin
                    w_wr_en = w_accept;
                    n_count = r_count + CNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (!w_empty) begin
                    n_head  = wrap_add(r_head, CNT_W'(1));
                    n_count = r_count - CNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            MODE_POP_REAR: begin
                if (!w_empty) begin
                    n_count = r_count - CNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            MODE_STATUS: begin
                n_ok = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        w_rd_en   = 1'b0;
        w_rd_addr = r_head;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_FRONT;
                end
            end
            S_FRONT: begin
                w_rd_en = 1'b1;
                n_state = S_REAR;
            end
            S_REAR: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_rear_addr;
                n_state   = S_LAST;
            end
            S_LAST: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    bdq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (s_axis_tdata[WORD_BITS-1:0]),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_ok        <= 1'b0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_head  <= n_head;
                r_count <= n_count;
                r_ok    <= n_ok;
            end
            if (r_state == S_LAST && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_REAR) begin
            r_front <= w_rd_data;
        end
        if (r_state == S_LAST && w_out_free) begin
            r_out_data <= {(OUT_TDATA_W-OUT_FIELD_W)'(0), w_full, w_empty,
                           {WORD_BITS{w_empty}} | w_rd_data,
                           {WORD_BITS{w_empty}} | r_front, r_ok};
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(STORE_DEPTH) >= r_count)
        else $error("entry count above storage depth");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_full &&
         (w_mode == MODE_PUSH_FRONT || w_mode == MODE_PUSH_REAR))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("successful push did not raise the count");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_empty &&
         (w_mode == MODE_POP_FRONT || w_mode == MODE_POP_REAR))
        |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("successful pop did not lower the count");

    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[65]) |-> (r_out_data[64:1] == '1))
        else $error("empty result carries stale words");
`endif

endmodule
